[rtl/core/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Shared constants, codes and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned ADDR_W           = 32;
  localparam int unsigned BLOCK_BYTES      = 4096;
  localparam int unsigned BLOCK_SHIFT      = $clog2(BLOCK_BYTES);
  localparam int unsigned TABLE_BLOCKS_DEF = 256;
  localparam int unsigned BIU_W            = 9;
  localparam logic [BIU_W-1:0] BIU_RESET   = 9'd256;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned ENTRY_W          = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  // Bit positions inside one table entry.
  localparam int unsigned MARK_TAKEN = 0;
  localparam int unsigned MARK_FIRST = 1;
  localparam int unsigned MARK_NEXT  = 2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_BADADDR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_WALK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    clear;
    logic    load;
    logic    scan;
    logic    mark;
    logic    walk;
    logic    resp_load;
    status_e resp_code;
    logic    resp_addr;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic req_free;
    logic req_bad;
    logic scan_hit;
    logic scan_miss;
    logic mark_done;
    logic walk_done;
  } stat_t;

endpackage

[rtl/core/first_fit_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// First-fit block allocator
// A request is either an allocate (func_i low, size in request_bytes_i) or a
// free (func_i high, address in free_address_i); each request yields exactly
// one result on the output channel: an address and a status code.
// Both channels use valid/ready. One request is worked on at a time; a new
// one is taken as soon as the previous result sits in the output register,
// even while the receiver stalls it. A finished result waits in the working
// state until the output register is free.
// An allocate scans the table for the first fitting run and then marks it;
// the table memory is read once per cycle during the scan and written once
// per cycle while the run is marked. A free walks its run and clears each
// entry, and a rejected request goes straight to its result.
// After reset a clearing pass writes every table entry as free, one per
// cycle; no request is taken during it, while configuration writes are.
// base_address resets to 0, blocks_in_use to 256.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
  parameter int unsigned TABLE_BLOCKS = ffa_pkg::TABLE_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ffa_pkg::ADDR_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [ffa_pkg::ADDR_W-1:0]    request_bytes_i,
  input  logic [ffa_pkg::ADDR_W-1:0]    free_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ffa_pkg::ADDR_W-1:0]    result_address_o,
  output logic [ffa_pkg::STATUS_W-1:0]  status_o
);

  ffa_pkg::cmd_t  cmd;
  ffa_pkg::stat_t stat;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffa_dp #(
    .TABLE_BLOCKS (TABLE_BLOCKS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .func_i           (func_i),
    .request_bytes_i  (request_bytes_i),
    .free_address_i   (free_address_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .result_address_o (result_address_o),
    .status_o         (status_o)
  );

  // The block is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while the previous one is still in work");

  // Failed requests and frees always report a zero address.
  a_zero_addr_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ffa_pkg::STAT_OK)) |-> (result_address_o == '0))
    else $error("nonzero address with a failing status");

  // A result only appears after the block has been busy working on it.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result shown without a preceding working cycle");

endmodule

[rtl/core/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// First-fit block allocator controller
// Sequences the clearing pass, the allocate scan and marking, the free walk
// and the hand-off of each result into the output register.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ffa_pkg::stat_t stat_i,
  output ffa_pkg::cmd_t  cmd_o
);

  ffa_pkg::state_e  state_q, state_d;
  ffa_pkg::status_e code_q, code_d;
  logic             addr_q, addr_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             slot_free;

  assign accept    = in_valid_i && (state_q == ffa_pkg::S_IDLE);
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    addr_d  = addr_q;
    case (state_q)
      ffa_pkg::S_CLEAR: begin
        if (stat_i.clear_done) state_d = ffa_pkg::S_IDLE;
      end
      ffa_pkg::S_IDLE: begin
        if (accept) begin
          addr_d = 1'b0;
          if (stat_i.req_free) begin
            code_d  = stat_i.req_bad ? ffa_pkg::STAT_BADADDR : ffa_pkg::STAT_OK;
            state_d = stat_i.req_bad ? ffa_pkg::S_RESP : ffa_pkg::S_WALK;
          end else begin
            code_d  = ffa_pkg::STAT_NOSPACE;
            state_d = stat_i.req_bad ? ffa_pkg::S_RESP : ffa_pkg::S_SCAN;
          end
        end
      end
      ffa_pkg::S_SCAN: begin
        if (stat_i.scan_hit) begin
          state_d = ffa_pkg::S_MARK;
        end else if (stat_i.scan_miss) begin
          code_d  = ffa_pkg::STAT_NOSPACE;
          state_d = ffa_pkg::S_RESP;
        end
      end
      ffa_pkg::S_MARK: begin
        if (stat_i.mark_done) begin
          code_d  = ffa_pkg::STAT_OK;
          addr_d  = 1'b1;
          state_d = ffa_pkg::S_RESP;
        end
      end
      ffa_pkg::S_WALK: begin
        if (stat_i.walk_done) state_d = ffa_pkg::S_RESP;
      end
      ffa_pkg::S_RESP: begin
        if (slot_free) state_d = ffa_pkg::S_IDLE;
      end
      default: state_d = ffa_pkg::S_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd_o           = '0;
    cmd_o.resp_code = code_q;
    cmd_o.resp_addr = addr_q;
    in_ready_o      = 1'b0;
    out_valid_d     = out_valid_q && !out_ready_i;
    case (state_q)
      ffa_pkg::S_CLEAR: cmd_o.clear = 1'b1;
      ffa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = accept;
      end
      ffa_pkg::S_SCAN: cmd_o.scan = 1'b1;
      ffa_pkg::S_MARK: cmd_o.mark = 1'b1;
      ffa_pkg::S_WALK: cmd_o.walk = 1'b1;
      ffa_pkg::S_RESP: begin
        if (slot_free) begin
          cmd_o.resp_load = 1'b1;
          out_valid_d     = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffa_pkg::S_CLEAR;
      code_q      <= ffa_pkg::STAT_OK;
      addr_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/ffa_dp.sv]
// ----------------------------------------------------------------------------
// First-fit block allocator datapath
// Holds the configuration registers, the block table memory, the scan and
// walk pointers and the result register.
// ----------------------------------------------------------------------------
module ffa_dp #(
  parameter int unsigned TABLE_BLOCKS = ffa_pkg::TABLE_BLOCKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ffa_pkg::ADDR_W-1:0]      cfg_wdata_i,
  input  logic                            func_i,
  input  logic [ffa_pkg::ADDR_W-1:0]      request_bytes_i,
  input  logic [ffa_pkg::ADDR_W-1:0]      free_address_i,
  input  ffa_pkg::cmd_t                   cmd_i,
  output ffa_pkg::stat_t                  stat_o,
  output logic [ffa_pkg::ADDR_W-1:0]      result_address_o,
  output logic [ffa_pkg::STATUS_W-1:0]    status_o
);

  localparam int unsigned IW   = $clog2(TABLE_BLOCKS);
  localparam int unsigned CW   = $clog2(TABLE_BLOCKS + 1);
  localparam int unsigned NW   = (CW > ffa_pkg::BIU_W) ? CW : ffa_pkg::BIU_W;
  localparam int unsigned WW   = ffa_pkg::ADDR_W - ffa_pkg::BLOCK_SHIFT + 1;
  localparam int unsigned CMPW = (WW > CW) ? WW : CW;
  localparam int unsigned EW   = ffa_pkg::ENTRY_W;

  logic [ffa_pkg::ADDR_W-1:0] base_q, base_d;
  logic [ffa_pkg::BIU_W-1:0]  biu_q, biu_d;
  logic [CW-1:0]              ptr_q, ptr_d;
  logic                       pend_q, pend_d;
  logic [IW-1:0]              chk_q, chk_d;
  logic [IW-1:0]              start_q, start_d;
  logic [CW-1:0]              run_q, run_d;
  logic [CW-1:0]              want_q, want_d;
  logic [CW-1:0]              mark_q, mark_d;
  logic [EW-1:0]              rd_q;
  logic [ffa_pkg::ADDR_W-1:0] res_addr_q;
  ffa_pkg::status_e           res_code_q;

  logic [EW-1:0] mem [TABLE_BLOCKS];

  logic [CW-1:0]              eff_n;
  logic [NW-1:0]              biu_ext;
  logic [WW-1:0]              want_full;
  logic [ffa_pkg::ADDR_W-1:0] free_off;
  logic [ffa_pkg::ADDR_W-1:0] free_idx;
  logic                       alloc_bad;
  logic                       free_bad;
  logic                       issue;
  logic                       hit;
  logic [IW-1:0]              start_new;
  logic                       rd_en;
  logic [IW-1:0]              rd_addr;
  logic                       wr_en;
  logic [IW-1:0]              wr_addr;
  logic [EW-1:0]              wr_data;

  // The managed block count is the register limited to the table size.
  assign biu_ext = NW'(biu_q);
  assign eff_n   = (biu_ext > NW'(TABLE_BLOCKS)) ? CW'(TABLE_BLOCKS) : CW'(biu_ext);

  assign want_full = WW'(request_bytes_i >> ffa_pkg::BLOCK_SHIFT)
                   + WW'(|request_bytes_i[ffa_pkg::BLOCK_SHIFT-1:0]);
  assign alloc_bad = (want_full == '0) || (CMPW'(want_full) > CMPW'(eff_n));

  assign free_off = free_address_i - base_q;
  assign free_idx = free_off >> ffa_pkg::BLOCK_SHIFT;
  assign free_bad = free_idx >= ffa_pkg::ADDR_W'(eff_n);

  assign issue     = ptr_q < eff_n;
  assign start_new = (run_q == '0) ? chk_q : start_q;
  assign hit       = pend_q && !rd_q[ffa_pkg::MARK_TAKEN] && ((run_q + CW'(1)) == want_q);

  assign stat_o.clear_done = ptr_q == CW'(TABLE_BLOCKS - 1);
  assign stat_o.req_free   = func_i;
  assign stat_o.req_bad    = func_i ? free_bad : alloc_bad;
  assign stat_o.scan_hit   = hit;
  assign stat_o.scan_miss  = !pend_q && !issue;
  assign stat_o.mark_done  = (mark_q + CW'(1)) == want_q;
  assign stat_o.walk_done  = pend_q && (!rd_q[ffa_pkg::MARK_NEXT]
                             || ((CW'(chk_q) + CW'(1)) >= eff_n));

  always_comb begin
    base_d  = base_q;
    biu_d   = biu_q;
    ptr_d   = ptr_q;
    pend_d  = pend_q;
    chk_d   = chk_q;
    start_d = start_q;
    run_d   = run_q;
    want_d  = want_q;
    mark_d  = mark_q;
    rd_en   = 1'b0;
    rd_addr = ptr_q[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr_q[IW-1:0];
    wr_data = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        ffa_pkg::CFG_BASE_ADDRESS:  base_d = cfg_wdata_i;
        ffa_pkg::CFG_BLOCKS_IN_USE: biu_d  = cfg_wdata_i[ffa_pkg::BIU_W-1:0];
        default:                    base_d = base_q;
      endcase
    end

    if (cmd_i.clear) begin
      wr_en = 1'b1;
      ptr_d = ptr_q + CW'(1);
    end

    if (cmd_i.load) begin
      pend_d = 1'b0;
      run_d  = '0;
      want_d = CW'(want_full);
      ptr_d  = func_i ? CW'(free_idx) : '0;
    end

    // Scan and walk both read one entry ahead of the one being checked.
    if (cmd_i.scan || cmd_i.walk) begin
      rd_en  = issue;
      pend_d = issue;
      chk_d  = ptr_q[IW-1:0];
      if (issue) ptr_d = ptr_q + CW'(1);
    end

    if (cmd_i.scan && pend_q) begin
      if (rd_q[ffa_pkg::MARK_TAKEN]) begin
        run_d = '0;
      end else begin
        start_d = start_new;
        run_d   = run_q + CW'(1);
      end
      if (hit) begin
        ptr_d  = CW'(start_new);
        mark_d = '0;
      end
    end

    if (cmd_i.walk && pend_q) begin
      wr_en   = 1'b1;
      wr_addr = chk_q;
    end

    if (cmd_i.mark) begin
      wr_en                       = 1'b1;
      wr_data[ffa_pkg::MARK_TAKEN] = 1'b1;
      wr_data[ffa_pkg::MARK_FIRST] = mark_q == '0;
      wr_data[ffa_pkg::MARK_NEXT]  = (mark_q + CW'(1)) < want_q;
      ptr_d                       = ptr_q + CW'(1);
      mark_d                      = mark_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      biu_q  <= ffa_pkg::BIU_RESET;
      ptr_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      base_q <= base_d;
      biu_q  <= biu_d;
      ptr_q  <= ptr_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q   <= chk_d;
    start_q <= start_d;
    run_q   <= run_d;
    want_q  <= want_d;
    mark_q  <= mark_d;
    if (cmd_i.resp_load) begin
      res_code_q <= cmd_i.resp_code;
      res_addr_q <= cmd_i.resp_addr
                  ? base_q + (ffa_pkg::ADDR_W'(start_q) << ffa_pkg::BLOCK_SHIFT)
                  : '0;
    end
  end

  // Block table memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign result_address_o = res_addr_q;
  assign status_o         = res_code_q;

endmodule

[bench/tb_first_fit_block_allocator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit block allocator testbench
// Drives allocate and free requests through the valid/ready input channel,
// predicts every result from a private copy of the block table and the two
// registers, and compares each result taken from the output channel with the
// oldest prediction. Registers change between phases, once the block is idle.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_unit;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam int unsigned NUM_PHASES = 7;

  typedef struct packed {
    logic [ffa_pkg::ADDR_W-1:0] addr;
    ffa_pkg::status_e           status;
  } heap_result_t;

  class HeapScoreboard;
    logic [ffa_pkg::ENTRY_W-1:0] marks [ffa_pkg::TABLE_BLOCKS_DEF];
    logic [ffa_pkg::ADDR_W-1:0]  base_addr;
    logic [ffa_pkg::BIU_W-1:0]   blocks_cfg;
    heap_result_t                owed_results [$];
    logic [ffa_pkg::ADDR_W-1:0]  live_addrs [$];
    int unsigned                 errors;

    function new();
      foreach (marks[i]) marks[i] = '0;
      base_addr  = '0;
      blocks_cfg = ffa_pkg::BIU_RESET;
      errors     = 0;
    endfunction

    function int unsigned eff_count();
      return (blocks_cfg > ffa_pkg::TABLE_BLOCKS_DEF) ? ffa_pkg::TABLE_BLOCKS_DEF
                                                      : blocks_cfg;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    function void set_config(logic [ffa_pkg::CFG_IDX_W-1:0] idx,
                             logic [ffa_pkg::ADDR_W-1:0] val);
      if (idx == ffa_pkg::CFG_BASE_ADDRESS) begin
        base_addr = val;
        // Addresses handed out under the old base no longer name their runs.
        live_addrs.delete();
      end else begin
        blocks_cfg = val[ffa_pkg::BIU_W-1:0];
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Applies one accepted request to the table copy and queues its result.
    function void note_request(logic op, logic [ffa_pkg::ADDR_W-1:0] bytes,
                               logic [ffa_pkg::ADDR_W-1:0] addr);
      heap_result_t                r;
      int unsigned                 n, want, run, start, k, j;
      bit                          found;
      logic [ffa_pkg::ADDR_W-1:0]  offset;
      logic [ffa_pkg::ADDR_W-1:0]  blk_addr;
      logic [ffa_pkg::ENTRY_W-1:0] e;
      r.addr   = '0;
      r.status = ffa_pkg::STAT_OK;
      n        = eff_count();
      if (op == OP_ALLOC) begin
        want = bytes >> ffa_pkg::BLOCK_SHIFT;
        if (bytes[ffa_pkg::BLOCK_SHIFT-1:0] != '0) want++;
        found = 1'b0;
        run   = 0;
        start = 0;
        if (want != 0 && want <= n) begin
          for (k = 0; k < n; k++) begin
            if (marks[k][ffa_pkg::MARK_TAKEN]) begin
              run = 0;
            end else begin
              if (run == 0) start = k;
              run++;
              if (run == want) begin
                found = 1'b1;
                break;
              end
            end
          end
        end
        if (!found) begin
          r.status = ffa_pkg::STAT_NOSPACE;
        end else begin
          for (k = 0; k < want; k++) begin
            e = '0;
            e[ffa_pkg::MARK_TAKEN] = 1'b1;
            if (k == 0) e[ffa_pkg::MARK_FIRST] = 1'b1;
            if (k + 1 < want) e[ffa_pkg::MARK_NEXT] = 1'b1;
            marks[start + k] = e;
          end
          r.addr = base_addr + (start << ffa_pkg::BLOCK_SHIFT);
          live_addrs.push_back(r.addr);
        end
      end else begin
        offset = addr - base_addr;
        k      = offset >> ffa_pkg::BLOCK_SHIFT;
        if (k >= n) begin
          r.status = ffa_pkg::STAT_BADADDR;
        end else begin
          // The walk clears whatever it finds until an entry has no successor or the table ends.
          for (; k < n; k++) begin
            e        = marks[k];
            marks[k] = '0;
            if (!e[ffa_pkg::MARK_NEXT]) break;
          end
          blk_addr = {addr[ffa_pkg::ADDR_W-1:ffa_pkg::BLOCK_SHIFT],
                      {ffa_pkg::BLOCK_SHIFT{1'b0}}};
          for (j = 0; j < live_addrs.size(); j++) begin
            if (live_addrs[j] == blk_addr) begin
              live_addrs.delete(j);
              break;
            end
          end
        end
      end
      owed_results.push_back(r);
    endfunction

    task check_result(logic [ffa_pkg::ADDR_W-1:0] addr,
                      logic [ffa_pkg::STATUS_W-1:0] status);
      heap_result_t want_r;
      if (owed_results.size() == 0) begin
        report($sformatf("result with no request pending: addr=%h status=%0d",
                         addr, status));
        return;
      end
      want_r = owed_results.pop_front();
      if (addr !== want_r.addr)
        report($sformatf("result_address %h, predicted %h", addr, want_r.addr));
      if (status !== want_r.status)
        report($sformatf("status %0d, predicted %0d", status, want_r.status));
    endtask
  endclass

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [ffa_pkg::ADDR_W-1:0]    cfg_wdata_i     = '0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_ready_o;
  logic                          func_i          = 1'b0;
  logic [ffa_pkg::ADDR_W-1:0]    request_bytes_i = '0;
  logic [ffa_pkg::ADDR_W-1:0]    free_address_i  = '0;
  logic                          out_valid_o;
  logic                          out_ready_i     = 1'b0;
  logic [ffa_pkg::ADDR_W-1:0]    result_address_o;
  logic [ffa_pkg::STATUS_W-1:0]  status_o;

  HeapScoreboard sb;
  int unsigned   burst_left = 0;
  int unsigned   ready_mode = 0;
  int unsigned   ready_hold = 0;

  logic [ffa_pkg::ADDR_W-1:0] phase_base [NUM_PHASES] = '{32'hFFFF_0000, 32'h1000_0000,
                                                          32'h8000_0000, 32'h0000_0000,
                                                          32'hABCD_E000, 32'h0004_0000,
                                                          32'hFFFF_F000};
  int unsigned phase_biu   [NUM_PHASES] = '{256, 1, 16, 0, 511, 64, 200};
  int unsigned phase_items [NUM_PHASES] = '{350, 100, 300, 40, 300, 350, 350};

  first_fit_block_allocator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .request_bytes_i (request_bytes_i),
    .free_address_i  (free_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_address_o(result_address_o),
    .status_o        (status_o)
  );

  always #4 clk_i = ~clk_i;

  // The receiver switches between always ready, random stalls and long stalls.
  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_hold = $urandom_range(8, 64);
    end
    ready_hold--;
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(result_address_o, status_o);
  end

  task write_reg(input logic [ffa_pkg::CFG_IDX_W-1:0] idx,
                 input logic [ffa_pkg::ADDR_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(idx, val);
    @(posedge clk_i);
  endtask

  task send_request(input logic op, input logic [ffa_pkg::ADDR_W-1:0] bytes,
                    input logic [ffa_pkg::ADDR_W-1:0] addr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    func_i          <= op;
    request_bytes_i <= bytes;
    free_address_i  <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, bytes, addr);
    burst_left--;
  endtask

  // Holds the sender back until every outstanding request has its result.
  task drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Mostly allocations and frees of live runs; the rest is malformed traffic.
  task random_item();
    int unsigned                sel, kind, n, pick;
    logic [ffa_pkg::ADDR_W-1:0] bytes, addr;
    sel   = $urandom_range(0, 99);
    kind  = $urandom_range(0, 99);
    n     = sb.eff_count();
    bytes = $urandom();
    addr  = $urandom();
    if (sel < 52) begin
      if (kind < 70)      bytes = $urandom_range(1, 4 * ffa_pkg::BLOCK_BYTES);
      else if (kind < 85) bytes = $urandom_range(1, 16 * ffa_pkg::BLOCK_BYTES);
      else if (kind < 92) bytes = $urandom_range(1, 8) << ffa_pkg::BLOCK_SHIFT;
      else if (kind < 95) bytes = '0;
      else if (kind < 97) bytes = $urandom();
      else                bytes = $urandom_range(64, 256) << ffa_pkg::BLOCK_SHIFT;
      send_request(OP_ALLOC, bytes, addr);
    end else begin
      if (kind < 75 && sb.live_addrs.size() != 0) begin
        pick = $urandom_range(0, sb.live_addrs.size() - 1);
        addr = sb.live_addrs[pick];
        if ($urandom_range(0, 3) == 0)
          addr = addr + $urandom_range(0, ffa_pkg::BLOCK_BYTES - 1);
      end else if (kind < 88) begin
        addr = sb.base_addr + ($urandom_range(0, n) << ffa_pkg::BLOCK_SHIFT)
               + $urandom_range(0, ffa_pkg::BLOCK_BYTES - 1);
      end else if (kind < 94) begin
        addr = sb.base_addr - $urandom_range(1, 2 * ffa_pkg::BLOCK_BYTES);
      end
      send_request(OP_FREE, bytes, addr);
    end
  endtask

  initial begin
    int unsigned p, i;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset settings: base 0, full table.
    send_request(OP_ALLOC, 32'h0000_0000, '0);
    send_request(OP_ALLOC, 32'h0000_0001, '0);
    send_request(OP_ALLOC, 32'h0000_1000, '0);
    send_request(OP_ALLOC, 32'h0000_1001, '0);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, '0);
    send_request(OP_ALLOC, 32'h0010_0000, '0);
    send_request(OP_FREE,  '0, 32'h0000_1000);
    send_request(OP_ALLOC, 32'h0000_1000, '0);
    send_request(OP_FREE,  '0, 32'h0000_2ABC);
    // Block three is already free, so this walks an unowned entry.
    send_request(OP_FREE,  '0, 32'h0000_3000);
    send_request(OP_FREE,  '0, 32'h0010_0000);
    send_request(OP_FREE,  '0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'h0000_3000, '0);
    // Freeing from the middle of a run leaves its head marked.
    send_request(OP_FREE,  '0, 32'h0000_3000);
    send_request(OP_ALLOC, 32'h0000_2000, '0);
    send_request(OP_FREE,  '0, 32'h0000_2000);
    send_request(OP_FREE,  '0, 32'h0000_0000);
    send_request(OP_FREE,  '0, 32'h0000_1000);
    send_request(OP_ALLOC, 32'h000F_A000, '0);
    // Only six blocks remain at the end of the table.
    send_request(OP_ALLOC, 32'h0000_A000, '0);
    send_request(OP_ALLOC, 32'h0000_6000, '0);
    send_request(OP_ALLOC, 32'h0000_0001, '0);
    send_request(OP_FREE,  '0, 32'h000F_A000);
    send_request(OP_FREE,  '0, 32'h0000_0000);
    send_request(OP_ALLOC, 32'h0010_0000, '0);
    // Clearing the last block first makes the next walk stop at the table end.
    send_request(OP_FREE,  '0, 32'h000F_FFFF);
    send_request(OP_FREE,  '0, 32'h0000_0000);

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_reg(ffa_pkg::CFG_BASE_ADDRESS, phase_base[p]);
      write_reg(ffa_pkg::CFG_BLOCKS_IN_USE, phase_biu[p]);
      for (i = 0; i < phase_items[p]; i++) begin
        if ($urandom_range(0, 249) == 0) drain_results();
        random_item();
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
